// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the LED animation sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while the active-low reset is asserted.
`define LAS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define LAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/las_pkg.sv =====
// Package with the codes, widths and LED pin tables of the LED animation sequencer.
package las_pkg;

	localparam int PosW = 11;
	localparam int PinW = 4;

	typedef logic [2:0] action_t;
	typedef logic [3:0] mode_t;
	typedef logic [1:0] team_t;
	typedef logic [2:0] led_idx_t;
	typedef logic [PinW-1:0] pins_t;
	typedef logic [PosW-1:0] pos_t;

	localparam action_t ACT_TICK    = 3'd0;
	localparam action_t ACT_REFRESH = 3'd1;
	localparam action_t ACT_MARK    = 3'd2;
	localparam action_t ACT_CLEAR   = 3'd3;
	localparam action_t ACT_LIGHT   = 3'd4;

	localparam mode_t MODE_OFF     = 4'd0;
	localparam mode_t MODE_PART    = 4'd1;
	localparam mode_t MODE_BLUE    = 4'd2;
	localparam mode_t MODE_RED     = 4'd3;
	localparam mode_t MODE_YELLOW  = 4'd4;
	localparam mode_t MODE_GREEN   = 4'd5;
	localparam mode_t MODE_CHASE1  = 4'd6;
	localparam mode_t MODE_CHASE2  = 4'd7;
	localparam mode_t MODE_FAST    = 4'd8;
	localparam mode_t MODE_BLUERED = 4'd9;
	localparam mode_t MODE_RESET   = MODE_CHASE2;

	localparam team_t TEAM_RED    = 2'd0;
	localparam team_t TEAM_YELLOW = 2'd1;
	localparam team_t TEAM_GREEN  = 2'd2;
	localparam team_t TEAM_BLUE   = 2'd3;

	localparam pos_t POS_HALF   = 11'd1024;

	// Pin number and latch level for each LED, left red..blue then right red..blue.
	localparam logic [1:0] LED_PIN [8] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2, 2'd2};
	localparam logic LED_LEVEL [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

	// LED index for a color on one side; colors above blue fall back to red.
	function automatic led_idx_t side_idx(input logic [3:0] color, input logic left);
		logic [1:0] c;
		c = (color > 4'd3) ? TEAM_RED : color[1:0];
		return {~left, c};
	endfunction

	// Team code of a team mode: blue, red, yellow, green for modes two to five.
	function automatic team_t team_code(input mode_t mode);
		return team_t'(mode[1:0] + 2'd1);
	endfunction

endpackage

// ===== src/led_animation_sequencer_top.sv =====
// Top level of the LED animation sequencer: input register, pattern logic and result register.

// The block takes one beat per clock cycle on the input channel while in_ready is high and holds
// it in an input register; when the beat fires, the pattern logic updates the position, the
// seen-team flags and the pin enables and latches, and a refresh or light beat loads the result
// register. Ticks, marks and clears give no result. The input side keeps accepting while a
// result waits, until a second result beat would have nowhere to go. The LED mode register is
// written through cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. It resets to the second chase mode.
`include "assert_macros.svh"

module led_animation_sequencer_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  las_pkg::mode_t       cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  las_pkg::action_t     action,
	input  las_pkg::team_t       team,
	input  las_pkg::led_idx_t    led_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output las_pkg::pins_t       pin_enable,
	output las_pkg::pins_t       pin_level,
	output logic                 ir_send,
	output las_pkg::team_t       ir_team
);

	las_pkg::mode_t    mode_q;
	las_pkg::pos_t     pos_q;
	logic [3:0]        seen_q;
	las_pkg::pins_t    enable_q;
	las_pkg::pins_t    latch_q;

	logic              valid_s1;
	las_pkg::action_t  action_s1;
	las_pkg::team_t    team_s1;
	las_pkg::led_idx_t led_index_s1;

	logic              out_valid_q;
	las_pkg::pins_t    pin_enable_q;
	las_pkg::pins_t    pin_level_q;
	logic              ir_send_q;
	las_pkg::team_t    ir_team_q;

	logic              has_result;
	logic              fire_s1;
	logic              do_clear;
	logic              do_light;
	las_pkg::led_idx_t light_idx;
	logic              send;
	las_pkg::team_t    code;
	las_pkg::team_t    tcode;
	las_pkg::pos_t     down_pos;
	las_pkg::pins_t    enable_n;
	las_pkg::pins_t    latch_n;
	logic [1:0]        pin_sel;

	assign has_result = (action_s1 == las_pkg::ACT_REFRESH) || (action_s1 == las_pkg::ACT_LIGHT);
	assign fire_s1    = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || fire_s1;

	assign tcode    = las_pkg::team_code(mode_q);
	assign down_pos = las_pkg::POS_HALF - pos_q;

	always_comb begin
		do_clear  = 1'b0;
		do_light  = 1'b0;
		light_idx = '0;
		send      = 1'b0;
		code      = las_pkg::TEAM_RED;
		if (action_s1 == las_pkg::ACT_LIGHT) begin
			do_clear  = 1'b1;
			do_light  = 1'b1;
			light_idx = led_index_s1;
		end else if (action_s1 == las_pkg::ACT_REFRESH) begin
			unique case (mode_q) inside
				las_pkg::MODE_OFF: begin
					do_clear = 1'b1;
				end
				las_pkg::MODE_PART: begin
					do_clear = 1'b1;
					if (!pos_q[10] && !pos_q[9]) begin
						do_light  = 1'b1;
						light_idx = las_pkg::side_idx({1'b0, pos_q[8:6]}, pos_q[0]);
					end else if (!pos_q[10]) begin
						// Sweeping back down from the middle of the first half.
						do_light  = 1'b1;
						light_idx = las_pkg::side_idx(down_pos[9:6], pos_q[0]);
					end else if (!pos_q[9]) begin
						if (!pos_q[8] && seen_q[las_pkg::TEAM_RED]) begin
							do_light  = 1'b1;
							light_idx = las_pkg::side_idx(4'(las_pkg::TEAM_RED), pos_q[4]);
						end else if (seen_q[las_pkg::TEAM_GREEN]) begin
							do_light  = 1'b1;
							light_idx = las_pkg::side_idx(4'(las_pkg::TEAM_GREEN), pos_q[4]);
						end
					end else begin
						if (!pos_q[8] && seen_q[las_pkg::TEAM_YELLOW]) begin
							do_light  = 1'b1;
							light_idx = las_pkg::side_idx(4'(las_pkg::TEAM_YELLOW), pos_q[4]);
						end else if (seen_q[las_pkg::TEAM_BLUE]) begin
							do_light  = 1'b1;
							light_idx = las_pkg::side_idx(4'(las_pkg::TEAM_BLUE), pos_q[4]);
						end
					end
				end
				las_pkg::MODE_BLUE, las_pkg::MODE_RED, las_pkg::MODE_YELLOW,
				las_pkg::MODE_GREEN: begin
					do_clear = 1'b1;
					code     = tcode;
					if (!pos_q[10]) begin
						if (pos_q == '0) begin
							send = 1'b1;
						end else begin
							do_light  = 1'b1;
							light_idx = las_pkg::side_idx({2'b00, tcode}, pos_q[0]);
						end
					end else begin
						// In the second half the color rotates every 256 positions.
						do_light  = 1'b1;
						light_idx = las_pkg::side_idx({2'b00, 2'(pos_q[9:8] + tcode)}, pos_q[0]);
					end
				end
				las_pkg::MODE_CHASE1: begin
					do_clear  = 1'b1;
					do_light  = 1'b1;
					light_idx = pos_q[7:5];
				end
				las_pkg::MODE_CHASE2: begin
					do_clear  = 1'b1;
					do_light  = 1'b1;
					light_idx = pos_q[8:6];
				end
				las_pkg::MODE_FAST: begin
					do_clear  = 1'b1;
					do_light  = 1'b1;
					light_idx = pos_q[6:4];
				end
				las_pkg::MODE_BLUERED: begin
					do_clear  = 1'b1;
					do_light  = 1'b1;
					light_idx = las_pkg::side_idx(pos_q[8] ? 4'(las_pkg::TEAM_BLUE)
						: 4'(las_pkg::TEAM_RED), pos_q[4]);
				end
				default: begin
				end
			endcase
		end
	end

	assign pin_sel = las_pkg::LED_PIN[light_idx];

	always_comb begin
		enable_n = do_clear ? '0 : enable_q;
		latch_n  = latch_q;
		if (do_light) begin
			enable_n[pin_sel] = 1'b1;
			latch_n[pin_sel]  = las_pkg::LED_LEVEL[light_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= las_pkg::MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1    <= action;
			team_s1      <= team;
			led_index_s1 <= led_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			seen_q   <= '0;
			enable_q <= '0;
			latch_q  <= '0;
		end else if (fire_s1) begin
			case (action_s1)
				las_pkg::ACT_TICK:  pos_q <= pos_q + 1'b1;
				las_pkg::ACT_MARK:  seen_q[team_s1] <= 1'b1;
				las_pkg::ACT_CLEAR: seen_q <= '0;
				default: begin
					enable_q <= enable_n;
					latch_q  <= latch_n;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result) begin
			pin_enable_q <= enable_n;
			pin_level_q  <= latch_n;
			ir_send_q    <= send;
			ir_team_q    <= send ? code : las_pkg::TEAM_RED;
		end
	end

	assign out_valid  = out_valid_q;
	assign pin_enable = pin_enable_q;
	assign pin_level  = pin_level_q;
	assign ir_send    = ir_send_q;
	assign ir_team    = ir_team_q;

	`LAS_ASSERT(a_tick_advances, clk, arst_n,
		(fire_s1 && action_s1 == las_pkg::ACT_TICK) |=>
		(pos_q == las_pkg::pos_t'($past(pos_q) + 1'b1)),
		"position did not advance on a tick")
	`LAS_ASSERT(a_send_all_off, clk, arst_n,
		(out_valid && ir_send) |-> (pin_enable == '0), "infrared send with a pin driven")
	`LAS_ASSERT(a_no_send_no_team, clk, arst_n,
		(out_valid && !ir_send) |-> (ir_team == las_pkg::TEAM_RED), "team code without a send")
	`LAS_ASSERT(a_one_pin, clk, arst_n, $onehot0(enable_q), "more than one pin driven")
	`LAS_ASSERT(a_stall_cause, clk, arst_n,
		!in_ready |-> (valid_s1 && has_result && out_valid && !out_ready),
		"input stalled without a pending result")

endmodule
